// ----- rtl/core/mrss_pkg.sv -----
// Shared types and constants of the mark range segment splitter.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package mrss_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned ROW_BITS_DEF     = 48;

  // Fixed field widths
  localparam int unsigned MARK_BITS = 32;
  localparam int unsigned SLOT_BITS = 48;
  localparam int unsigned PART_BITS = 16;
  localparam int unsigned SEGN_BITS = 6;

  // Configuration register widths
  localparam int unsigned GRAN_BITS    = 17;
  localparam int unsigned MINROWS_BITS = 48;
  localparam int unsigned MAXCNT_BITS  = 7;
  localparam int unsigned TOTAL_BITS   = 32;
  localparam int unsigned REPL_BITS    = 16;
  localparam int unsigned CFG_DATA_BITS = 48;
  localparam int unsigned CFG_IDX_BITS  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_GRANULARITY = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MIN_ROWS    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MAX_COUNT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOTAL_MARKS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_REPLICA     = 3'd4;

  // Configuration reset values
  localparam logic [GRAN_BITS-1:0]    CFG_GRAN_RST    = 17'd8192;
  localparam logic [MINROWS_BITS-1:0] CFG_MINROWS_RST = 48'd1048576;
  localparam logic [MAXCNT_BITS-1:0]  CFG_MAXCNT_RST  = 7'd64;
  localparam logic [TOTAL_BITS-1:0]   CFG_TOTAL_RST   = 32'd0;
  localparam logic [REPL_BITS-1:0]    CFG_REPL_RST    = 16'd0;

  typedef struct packed {
    logic [GRAN_BITS-1:0]    granularity;
    logic [MINROWS_BITS-1:0] min_segment_rows;
    logic [MAXCNT_BITS-1:0]  max_segment_count;
    logic [TOTAL_BITS-1:0]   total_marks;
    logic [REPL_BITS-1:0]    replica_offset;
  } cfg_regs_t;

  typedef struct packed {
    logic [PART_BITS-1:0] part_id;
    logic [PART_BITS-1:0] part_query_index;
    logic [MARK_BITS-1:0] range_start;
    logic [MARK_BITS-1:0] range_stop;
    logic                 new_part;
  } in_item_t;

  typedef struct packed {
    logic [SEGN_BITS-1:0] segment_number;
    logic [SLOT_BITS-1:0] slot_number;
    logic [PART_BITS-1:0] piece_part;
    logic [MARK_BITS-1:0] piece_start;
    logic [MARK_BITS-1:0] piece_stop;
    logic                 last_piece;
    logic                 config_error;
  } out_item_t;

  // Shared multiply/divide unit
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } arith_sts_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_T,
    ST_DIV_K,
    ST_DIV_SIZE,
    ST_DIV_Q,
    ST_MUL_SIZE,
    ST_DIV_CNT,
    ST_MUL_SLOT,
    ST_EMIT
  } ctrl_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/mrss_arith.sv -----
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
// Depends on mrss_pkg.
`default_nettype none

module mrss_arith import mrss_pkg::*; #(
  parameter int unsigned UW = 49
) (
  input  logic          clk,
  input  logic          rst_n,
  input  arith_ctl_t    ctl,
  input  logic [UW-1:0] opa,
  input  logic [UW-1:0] opb,
  output arith_sts_t    sts,
  output logic [UW-1:0] acc,
  output logic [UW-1:0] quo
);

  localparam int unsigned CNTW = $clog2(UW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  arith_op_t       op_r, op_nxt;
  logic            ovf_r, ovf_nxt;
  logic [UW-1:0]   acc_r, acc_nxt;
  logic [UW-1:0]   x_r, x_nxt;
  logic [UW-1:0]   y_r, y_nxt;

  logic            is_sub;
  logic [UW:0]     lhs;
  logic [UW-1:0]   rhs;
  logic [UW+1:0]   sum;
  logic            qbit;

  // One add/subtract per step: shift-add for multiply, trial subtract for divide
  assign is_sub = (op_r == OP_DIV);
  assign lhs    = is_sub ? {acc_r, x_r[UW-1]} : {acc_r, 1'b0};
  assign rhs    = (is_sub || x_r[UW-1]) ? y_r : '0;
  assign sum    = {1'b0, lhs} + ({2'b00, rhs} ^ {(UW+2){is_sub}}) + (UW+2)'(is_sub);
  assign qbit   = ~sum[UW+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    ovf_nxt  = ovf_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(UW);
      op_nxt   = ctl.op;
      ovf_nxt  = 1'b0;
      acc_nxt  = '0;
      // multiply: y = multiplicand, x = multiplier; divide: x = dividend, y = divisor
      x_nxt    = (ctl.op == OP_DIV) ? opa : opb;
      y_nxt    = (ctl.op == OP_DIV) ? opb : opa;
    end else if (busy_r) begin
      unique case (op_r)
        OP_DIV: begin
          acc_nxt = qbit ? sum[UW-1:0] : lhs[UW-1:0];
          x_nxt   = {x_r[UW-2:0], qbit};
        end
        OP_MUL: begin
          acc_nxt = sum[UW-1:0];
          ovf_nxt = ovf_r | sum[UW+1] | sum[UW];
          x_nxt   = {x_r[UW-2:0], 1'b0};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    ovf_r <= ovf_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign acc      = acc_r;
  assign quo      = x_r;

endmodule

`default_nettype wire

// ----- rtl/core/mrss_cfg.sv -----
// Configuration register file of the segment splitter, with validity check.
// Depends on mrss_pkg.
`default_nettype none

module mrss_cfg import mrss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_regs_t                regs,
  output logic                     cfg_ok
);

  cfg_regs_t regs_r, regs_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_GRANULARITY: regs_nxt.granularity       = cfg_data[GRAN_BITS-1:0];
        CFG_IDX_MIN_ROWS:    regs_nxt.min_segment_rows  = cfg_data[MINROWS_BITS-1:0];
        CFG_IDX_MAX_COUNT:   regs_nxt.max_segment_count = cfg_data[MAXCNT_BITS-1:0];
        CFG_IDX_TOTAL_MARKS: regs_nxt.total_marks       = cfg_data[TOTAL_BITS-1:0];
        CFG_IDX_REPLICA:     regs_nxt.replica_offset    = cfg_data[REPL_BITS-1:0];
        default:             regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.granularity       <= CFG_GRAN_RST;
      regs_r.min_segment_rows  <= CFG_MINROWS_RST;
      regs_r.max_segment_count <= CFG_MAXCNT_RST;
      regs_r.total_marks       <= CFG_TOTAL_RST;
      regs_r.replica_offset    <= CFG_REPL_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  // Any zero among these makes every transaction an error result
  assign cfg_ok = (regs_r.granularity != '0) && (regs_r.min_segment_rows != '0) &&
                  (regs_r.max_segment_count != '0) && (regs_r.total_marks != '0);

endmodule

`default_nettype wire

// ----- rtl/core/mrss_ctrl.sv -----
// Sequencer of the segment splitter: one-time setup through the shared
// arithmetic unit, then per-range piece emission into the output register.
// Depends on mrss_pkg and mrss_arith.
`default_nettype none

module mrss_ctrl import mrss_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned ROW_BITS     = ROW_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t regs,
  input  logic      cfg_ok,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned CW   = (ROW_BITS > MINROWS_BITS) ? ROW_BITS : MINROWS_BITS;
  localparam int unsigned UW   = CW + 1;
  localparam int unsigned SEGW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SEGX = SEGW + SEGN_BITS;
  localparam int unsigned AW   = (ROW_BITS > MARK_BITS) ? ROW_BITS : MARK_BITS;

  ctrl_state_t          state_r, state_nxt;
  logic                 started_r, started_nxt;
  logic                 finished_r, finished_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [PART_BITS-1:0] part_r, part_nxt;
  logic [PART_BITS-1:0] query_r, query_nxt;
  logic [MARK_BITS-1:0] begin_r, begin_nxt;
  logic [MARK_BITS-1:0] stop_r, stop_nxt;
  logic [ROW_BITS-1:0]  t_r, t_nxt;
  logic [UW-1:0]        tmp_r, tmp_nxt;
  logic [ROW_BITS-1:0]  q_r, q_nxt;
  logic [SEGW-1:0]      total_r, total_nxt;
  logic [SEGW-1:0]      cur_r, cur_nxt;
  logic [ROW_BITS-1:0]  filled_r, filled_nxt;
  logic [SLOT_BITS-1:0] slot_ctr_r, slot_ctr_nxt;
  logic [SLOT_BITS-1:0] open_slot_r, open_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // Shared unit interface
  arith_ctl_t           a_ctl;
  arith_sts_t           a_sts;
  logic [UW-1:0]        a_opa, a_opb;
  logic [UW-1:0]        a_acc, a_quo;

  logic                 accept;
  logic                 out_free;
  logic                 op_state;
  logic [MAXCNT_BITS-1:0] maxc;
  logic [ROW_BITS-1:0]  t_sat;
  logic                 disabled;
  logic [UW-1:0]        div_ceil;
  logic [UW-1:0]        k_clamp;
  logic [SEGW-1:0]      cnt_clamp;
  logic [SLOT_BITS-1:0] slot_base;

  logic [ROW_BITS-1:0]  avail;
  logic [MARK_BITS-1:0] want;
  logic [AW-1:0]        take_w;
  logic [MARK_BITS-1:0] end_m;
  logic [ROW_BITS-1:0]  filled_sum;
  logic                 seg_full;
  logic [SEGW-1:0]      cur_inc;
  logic                 last_seg;
  logic                 range_done;
  logic                 piece_last;
  logic [SEGX-1:0]      seg_ext;
  out_item_t            piece;
  out_item_t            err_item;
  logic [MARK_BITS-1:0] stop_in;

  mrss_arith #(
    .UW (UW)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (a_ctl),
    .opa   (a_opa),
    .opb   (a_opb),
    .sts   (a_sts),
    .acc   (a_acc),
    .quo   (a_quo)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign op_state = (state_r == ST_MUL_T) || (state_r == ST_DIV_K) ||
                    (state_r == ST_DIV_SIZE) || (state_r == ST_DIV_Q) ||
                    (state_r == ST_MUL_SIZE) || (state_r == ST_DIV_CNT) ||
                    (state_r == ST_MUL_SLOT);

  // Setup arithmetic on the unit results
  assign maxc = (regs.max_segment_count > MAXCNT_BITS'(MAX_SEGMENTS)) ?
                MAXCNT_BITS'(MAX_SEGMENTS) : regs.max_segment_count;
  assign t_sat = (a_sts.ovf || (a_acc > UW'({ROW_BITS{1'b1}}))) ?
                 {ROW_BITS{1'b1}} : a_acc[ROW_BITS-1:0];
  assign disabled = (maxc <= MAXCNT_BITS'(1)) ||
                    (CW'(t_sat) <= CW'(regs.min_segment_rows));
  assign div_ceil  = a_quo + UW'(a_acc != '0);
  assign k_clamp   = (a_quo > UW'(maxc)) ? UW'(maxc) : a_quo;
  assign cnt_clamp = (div_ceil > UW'(MAX_SEGMENTS)) ? SEGW'(MAX_SEGMENTS) :
                     div_ceil[SEGW-1:0];
  assign slot_base = a_acc[SLOT_BITS-1:0] + SLOT_BITS'(query_r);

  // Piece of the current range that fits into the current segment (in marks)
  assign avail      = q_r - filled_r;
  assign want       = stop_r - begin_r;
  assign take_w     = (AW'(want) < AW'(avail)) ? AW'(want) : AW'(avail);
  assign end_m      = begin_r + take_w[MARK_BITS-1:0];
  assign filled_sum = filled_r + take_w[ROW_BITS-1:0];
  assign seg_full   = (filled_sum == q_r);
  assign cur_inc    = cur_r + SEGW'(1);
  assign last_seg   = (cur_inc >= total_r);
  assign range_done = (end_m == stop_r);
  assign piece_last = !seg_full || last_seg || range_done;
  assign seg_ext    = SEGX'(cur_r);
  assign stop_in    = (in_data.range_stop < in_data.range_start) ?
                      in_data.range_start : in_data.range_stop;

  always_comb begin
    piece                = '0;
    piece.segment_number = seg_ext[SEGN_BITS-1:0];
    piece.slot_number    = open_slot_r;
    piece.piece_part     = part_r;
    piece.piece_start    = begin_r;
    piece.piece_stop     = end_m;
    piece.last_piece     = piece_last;
    err_item              = '0;
    err_item.config_error = 1'b1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (!cfg_ok)    state_nxt = ST_ERR;
          else if (finished_r)     state_nxt = ST_IDLE;
          else if (!started_r)     state_nxt = ST_MUL_T;
          else                     state_nxt = ST_EMIT;
        end
      end
      ST_ERR:      if (out_free) state_nxt = ST_IDLE;
      ST_MUL_T:    if (a_sts.done) state_nxt = disabled ? ST_IDLE : ST_DIV_K;
      ST_DIV_K:    if (a_sts.done) state_nxt = ST_DIV_SIZE;
      ST_DIV_SIZE: if (a_sts.done) state_nxt = ST_DIV_Q;
      ST_DIV_Q:    if (a_sts.done) state_nxt = ST_MUL_SIZE;
      ST_MUL_SIZE: if (a_sts.done) state_nxt = ST_DIV_CNT;
      ST_DIV_CNT:  if (a_sts.done) state_nxt = ST_MUL_SLOT;
      ST_MUL_SLOT: if (a_sts.done) state_nxt = ST_EMIT;
      ST_EMIT:     if (out_free && piece_last) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: input handshake and operand selection for the shared unit
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    a_ctl.start = op_state && !a_sts.busy && !a_sts.done;
    a_ctl.op    = OP_DIV;
    a_opa       = '0;
    a_opb       = '0;
    unique case (state_r)
      ST_MUL_T: begin
        a_ctl.op = OP_MUL;
        a_opa    = UW'(regs.total_marks);
        a_opb    = UW'(regs.granularity);
      end
      ST_DIV_K: begin
        a_opa = UW'(t_r);
        a_opb = UW'(regs.min_segment_rows);
      end
      ST_DIV_SIZE: begin
        a_opa = UW'(t_r);
        a_opb = tmp_r;
      end
      ST_DIV_Q: begin
        a_opa = tmp_r;
        a_opb = UW'(regs.granularity);
      end
      ST_MUL_SIZE: begin
        a_ctl.op = OP_MUL;
        a_opa    = UW'(q_r);
        a_opb    = UW'(regs.granularity);
      end
      ST_DIV_CNT: begin
        a_opa = UW'(t_r);
        a_opb = tmp_r;
      end
      ST_MUL_SLOT: begin
        a_ctl.op = OP_MUL;
        a_opa    = UW'(regs.replica_offset);
        a_opb    = UW'(regs.total_marks);
      end
      default: begin
        a_ctl.op = OP_DIV;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    started_nxt   = started_r;
    finished_nxt  = finished_r;
    fresh_nxt     = fresh_r;
    part_nxt      = part_r;
    query_nxt     = query_r;
    begin_nxt     = begin_r;
    stop_nxt      = stop_r;
    t_nxt         = t_r;
    tmp_nxt       = tmp_r;
    q_nxt         = q_r;
    total_nxt     = total_r;
    cur_nxt       = cur_r;
    filled_nxt    = filled_r;
    slot_ctr_nxt  = slot_ctr_r;
    open_slot_nxt = open_slot_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          part_nxt  = in_data.part_id;
          query_nxt = in_data.part_query_index;
          begin_nxt = in_data.range_start;
          stop_nxt  = stop_in;
          if (cfg_ok && !finished_r) begin
            if (!started_r) begin
              started_nxt = 1'b1;
            end else begin
              // a new part opens its own slot unless a segment was just opened
              if (in_data.new_part && !fresh_r) begin
                open_slot_nxt = slot_ctr_r;
                slot_ctr_nxt  = slot_ctr_r + SLOT_BITS'(1);
              end
              fresh_nxt = 1'b0;
            end
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = err_item;
        end
      end
      ST_MUL_T: begin
        if (a_sts.done) begin
          t_nxt = t_sat;
          if (disabled) finished_nxt = 1'b1;
        end
      end
      ST_DIV_K:    if (a_sts.done) tmp_nxt = k_clamp;
      ST_DIV_SIZE: if (a_sts.done) tmp_nxt = a_quo;
      ST_DIV_Q:    if (a_sts.done) q_nxt = div_ceil[ROW_BITS-1:0];
      ST_MUL_SIZE: if (a_sts.done) tmp_nxt = a_acc;
      ST_DIV_CNT: begin
        if (a_sts.done) begin
          total_nxt  = cnt_clamp;
          cur_nxt    = '0;
          filled_nxt = '0;
        end
      end
      ST_MUL_SLOT: begin
        if (a_sts.done) begin
          open_slot_nxt = slot_base;
          slot_ctr_nxt  = slot_base + SLOT_BITS'(1);
          fresh_nxt     = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = piece;
          begin_nxt     = end_m;
          if (seg_full) begin
            cur_nxt = cur_inc;
            if (last_seg) begin
              finished_nxt = 1'b1;
              filled_nxt   = filled_sum;
            end else begin
              filled_nxt    = '0;
              open_slot_nxt = slot_ctr_r;
              slot_ctr_nxt  = slot_ctr_r + SLOT_BITS'(1);
              if (range_done) fresh_nxt = 1'b1;
            end
          end else begin
            filled_nxt = filled_sum;
          end
        end
      end
      default: begin
        out_data_nxt = out_data_r;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      cur_r       <= '0;
      filled_r    <= '0;
      slot_ctr_r  <= '0;
      open_slot_r <= '0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      finished_r  <= finished_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      cur_r       <= cur_nxt;
      filled_r    <= filled_nxt;
      slot_ctr_r  <= slot_ctr_nxt;
      open_slot_r <= open_slot_nxt;
    end
  end

  // Payload and setup operand registers
  always_ff @(posedge clk) begin
    part_r     <= part_nxt;
    query_r    <= query_nxt;
    begin_r    <= begin_nxt;
    stop_r     <= stop_nxt;
    t_r        <= t_nxt;
    tmp_r      <= tmp_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/mark_range_segment_splitter.sv -----
// Top level of the mark range segment splitter: configuration registers
// and the sequencer. Depends on mrss_pkg, mrss_cfg and mrss_ctrl.
`default_nettype none

// Cuts a stream of mark ranges into pieces at equal-size segment boundaries
// and tags each piece with its segment and output slot. The first accepted
// transaction after reset runs the setup: up to seven multiply/divide
// operations in turn on one shared bit-serial unit, before the first piece.
// After that each range is accepted while the sequencer is idle, and its
// pieces are emitted one per cycle through the single output register,
// stalling while out_ready is low; a new range waits for the last piece.
// With an invalid configuration each transaction yields one error result.
// Config writes are taken every cycle and must only happen while the block
// is idle.

module mark_range_segment_splitter import mrss_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned ROW_BITS     = ROW_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data
);

  cfg_regs_t regs;
  logic      cfg_ok;

  mrss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs),
    .cfg_ok    (cfg_ok)
  );

  mrss_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ROW_BITS     (ROW_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .cfg_ok    (cfg_ok),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
